/* hw/rtl/ffha_pkg.sv */
// Package: shared widths, microcode types and step addresses of the heap allocator.
package ffha_pkg;

  localparam int unsigned OFF_W  = 13;
  localparam int unsigned OP_W   = 2;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned IDX_W  = 11;
  localparam int unsigned REQ_W  = 12;
  localparam int unsigned STEP_W = 5;

  typedef logic [OFF_W-1:0]  off_t;
  typedef logic [OP_W-1:0]   op_t;
  typedef logic [WORD_W-1:0] word_t;
  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [STEP_W-1:0] step_t;

  localparam op_t OP_INIT  = 2'd0;
  localparam op_t OP_ALLOC = 2'd1;
  localparam op_t OP_FREE  = 2'd2;

  localparam word_t OCC_BIT   = 32'h8000_0000;
  localparam word_t SIZE_MASK = 32'h7fff_ffff;

  typedef enum logic [2:0] {
    C_ALWAYS     = 3'd0,
    C_NO_ITEM    = 3'd1,
    C_OPCODE     = 3'd2,
    C_I_GE_LIMIT = 3'd3,
    C_HDR        = 3'd4,
    C_FREE_BAD   = 3'd5,
    C_OUT_BUSY   = 3'd6
  } cond_e;

  typedef enum logic [2:0] {
    M_NONE    = 3'd0,
    M_RD_I    = 3'd1,
    M_RD_W    = 3'd2,
    M_WR_INIT = 3'd3,
    M_WR_HDR  = 3'd4,
    M_WR_MARK = 3'd5,
    M_WR_REM  = 3'd6,
    M_WR_FREE = 3'd7
  } mem_op_e;

  typedef enum logic [1:0] {
    R_NONE  = 2'd0,
    R_OK    = 2'd1,
    R_ALLOC = 2'd2,
    R_FAIL  = 2'd3
  } res_e;

  typedef enum logic [1:0] {
    HC_ADV   = 2'd0,
    HC_MARK  = 2'd1,
    HC_SPLIT = 2'd2,
    HC_STOP  = 2'd3
  } hdr_code_e;

  typedef struct packed {
    step_t   tgt;
    cond_e   cond;
    mem_op_e mem;
    logic    adv;
    res_e    res;
  } ctrl_t;

  localparam step_t S_IDLE   = 5'd0;
  localparam step_t S_DISP   = 5'd1;
  localparam step_t S_J_INIT = 5'd2;
  localparam step_t S_J_ALOC = 5'd3;
  localparam step_t S_J_FREE = 5'd4;
  localparam step_t S_J_BAD  = 5'd5;
  localparam step_t S_INIT   = 5'd6;
  localparam step_t S_ALOOP  = 5'd7;
  localparam step_t S_ACHK   = 5'd8;
  localparam step_t S_ADV    = 5'd9;
  localparam step_t S_MARK   = 5'd10;
  localparam step_t S_J_SPL  = 5'd11;
  localparam step_t S_J_STOP = 5'd12;
  localparam step_t S_SPLIT  = 5'd13;
  localparam step_t S_SREM   = 5'd14;
  localparam step_t S_FREE0  = 5'd15;
  localparam step_t S_FREE1  = 5'd16;
  localparam step_t S_FAIL   = 5'd17;
  localparam step_t S_EMIT   = 5'd31;

endpackage

/* hw/rtl/ffha_ram.sv */
// Generic single-port RAM with registered read data.
module ffha_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i && we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (en_i && !we_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/first_fit_heap_allocator_top.sv */
// Top level: microcoded first-fit heap allocator over a RAM of block headers.
//
//  channel | dir | handshake           | payload
//  --------+-----+---------------------+------------------------------------------
//  cfg     | in  | cfg_valid/cfg_ready | cfg_heap_bytes
//  in      | in  | in_valid/in_stall   | in_opcode, in_request_bytes, in_free_offset
//  out     | out | out_valid/out_stall | out_payload_offset, out_success
//
// One beat at a time runs through the control store, one step per cycle; emit waits on a stalled output.
// Init writes one header over the heap; free clears the occupied bit of the header before
// the payload; allocate walks headers, one RAM read per block, to mark, split or fail.
// Reset clears only control state; the header RAM is valid once init has run.
// A stalled output holds the finished result; the next beat is taken meanwhile.
module first_fit_heap_allocator_top #(
  parameter int unsigned HEAP_WORDS = 1024
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  ffha_pkg::off_t cfg_heap_bytes_i,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  ffha_pkg::op_t  in_opcode_i,
  input  ffha_pkg::off_t in_request_bytes_i,
  input  ffha_pkg::off_t in_free_offset_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output ffha_pkg::off_t out_payload_offset_o,
  output logic           out_success_o
);
  import ffha_pkg::*;

  localparam int unsigned AW = $clog2(HEAP_WORDS);

  function automatic ctrl_t rom(input step_t s);
    ctrl_t c;
    c = '{tgt: S_IDLE, cond: C_ALWAYS, mem: M_NONE, adv: 1'b0, res: R_NONE};
    case (s)
      S_IDLE:   begin c.tgt = S_IDLE;   c.cond = C_NO_ITEM; end
      S_DISP:   begin c.tgt = S_J_INIT; c.cond = C_OPCODE;  end
      S_J_INIT: c.tgt = S_INIT;
      S_J_ALOC: c.tgt = S_ALOOP;
      S_J_FREE: c.tgt = S_FREE0;
      S_J_BAD:  c.tgt = S_FAIL;
      S_INIT:   begin c.tgt = S_EMIT; c.mem = M_WR_INIT; c.res = R_OK; end
      S_ALOOP:  begin c.tgt = S_FAIL; c.cond = C_I_GE_LIMIT; c.mem = M_RD_I; end
      S_ACHK:   begin c.tgt = S_ADV;  c.cond = C_HDR; end
      S_ADV:    begin c.tgt = S_ALOOP; c.adv = 1'b1; end
      S_MARK:   begin c.tgt = S_EMIT; c.mem = M_WR_MARK; c.res = R_ALLOC; end
      S_J_SPL:  c.tgt = S_SPLIT;
      S_J_STOP: c.tgt = S_FAIL;
      S_SPLIT:  begin c.tgt = S_SREM; c.mem = M_WR_HDR; end
      S_SREM:   begin c.tgt = S_EMIT; c.mem = M_WR_REM; c.res = R_ALLOC; end
      S_FREE0:  begin c.tgt = S_FAIL; c.cond = C_FREE_BAD; c.mem = M_RD_W; end
      S_FREE1:  begin c.tgt = S_EMIT; c.mem = M_WR_FREE; c.res = R_OK; end
      S_FAIL:   begin c.tgt = S_EMIT; c.res = R_FAIL; end
      S_EMIT:   begin c.tgt = S_EMIT; c.cond = C_OUT_BUSY; end
      default:  c.tgt = S_IDLE;
    endcase
    return c;
  endfunction

  step_t              step_q, step_d;
  ctrl_t              cw;
  off_t               heap_q;
  op_t                op_q;
  logic [REQ_W-1:0]   req_w_q;
  idx_t               fw_q;
  idx_t               i_q, i_d;
  logic               res_ok_q, res_ok_d;
  off_t               res_off_q, res_off_d;
  logic               out_valid_q, out_valid_d;
  off_t               out_off_q;
  logic               out_ok_q;

  logic               in_accept;
  logic               emit_busy;
  idx_t               limit;
  logic [REQ_W-1:0]   reqp1;
  logic [30:0]        rq4;
  logic [30:0]        size;
  logic [29:0]        nxt;
  logic [12:0]        rem;
  logic               rem_ok;
  idx_t               w_idx;
  logic               free_bad;
  hdr_code_e          hcode;
  logic               jmp;
  logic [1:0]         ofs;

  logic               ram_en, ram_we;
  logic [AW-1:0]      ram_addr;
  word_t              ram_wdata, ram_rdata;

  assign cw        = rom(step_q);
  assign in_stall_o = (step_q != S_IDLE);
  assign in_accept = in_valid_i && !in_stall_o;
  assign emit_busy = out_valid_q && out_stall_i;
  assign cfg_ready_o = 1'b1;

  assign limit = (32'(heap_q[OFF_W-1:2]) > HEAP_WORDS) ? IDX_W'(HEAP_WORDS)
                                                       : heap_q[OFF_W-1:2];
  assign reqp1 = req_w_q + REQ_W'(1);
  assign rq4   = 31'({reqp1, 2'b00});
  assign size  = ram_rdata[30:0];
  assign nxt   = 30'(i_q) + 30'(size[30:2]);
  assign rem   = 13'(i_q) + 13'(reqp1);
  assign rem_ok = 32'(rem) < HEAP_WORDS;
  assign w_idx = fw_q - IDX_W'(1);
  assign free_bad = (fw_q == '0) || !(32'(w_idx) < HEAP_WORDS);

  always_comb begin
    if (!ram_rdata[31] && size > rq4) begin
      hcode = HC_SPLIT;
    end else if (!ram_rdata[31] && size == rq4) begin
      hcode = HC_MARK;
    end else if (size[30:2] == '0 || nxt >= 30'(limit)) begin
      hcode = HC_STOP;
    end else begin
      hcode = HC_ADV;
    end
  end

  always_comb begin
    jmp = 1'b0;
    ofs = 2'd0;
    case (cw.cond)
      C_ALWAYS:     jmp = 1'b1;
      C_NO_ITEM:    jmp = !in_valid_i;
      C_OPCODE:     begin jmp = 1'b1; ofs = op_q; end
      C_I_GE_LIMIT: jmp = (i_q >= limit);
      C_HDR:        begin jmp = 1'b1; ofs = hcode; end
      C_FREE_BAD:   jmp = free_bad;
      C_OUT_BUSY:   jmp = emit_busy;
      default:      jmp = 1'b1;
    endcase
    step_d = jmp ? (cw.tgt + STEP_W'(ofs)) : (step_q + STEP_W'(1));
  end

  always_comb begin
    ram_en    = 1'b0;
    ram_we    = 1'b0;
    ram_addr  = AW'(i_q);
    ram_wdata = ram_rdata;
    case (cw.mem)
      M_NONE:    ram_en = 1'b0;
      M_RD_I:    ram_en = 1'b1;
      M_RD_W:    begin ram_en = 1'b1; ram_addr = AW'(w_idx); end
      M_WR_INIT: begin
        ram_en = 1'b1; ram_we = 1'b1; ram_addr = '0;
        ram_wdata = WORD_W'({limit, 2'b00});
      end
      M_WR_HDR:  begin
        ram_en = 1'b1; ram_we = 1'b1;
        ram_wdata = WORD_W'(rq4) | OCC_BIT;
      end
      M_WR_MARK: begin
        ram_en = 1'b1; ram_we = 1'b1;
        ram_wdata = ram_rdata | OCC_BIT;
      end
      M_WR_REM:  begin
        ram_en = rem_ok; ram_we = 1'b1; ram_addr = AW'(rem);
        ram_wdata = WORD_W'(size - rq4) & SIZE_MASK;
      end
      M_WR_FREE: begin
        ram_en = 1'b1; ram_we = 1'b1; ram_addr = AW'(w_idx);
        ram_wdata = ram_rdata & SIZE_MASK;
      end
      default:   ram_en = 1'b0;
    endcase
  end

  always_comb begin
    i_d       = i_q;
    res_ok_d  = res_ok_q;
    res_off_d = res_off_q;
    if (in_accept) begin
      i_d = '0;
    end else if (cw.adv) begin
      i_d = nxt[IDX_W-1:0];
    end
    case (cw.res)
      R_NONE:  res_ok_d = res_ok_q;
      R_OK:    begin res_ok_d = 1'b1; res_off_d = '0; end
      R_ALLOC: begin res_ok_d = 1'b1; res_off_d = OFF_W'({i_q + IDX_W'(1), 2'b00}); end
      R_FAIL:  begin res_ok_d = 1'b0; res_off_d = '0; end
      default: res_ok_d = res_ok_q;
    endcase
    out_valid_d = out_valid_q && out_stall_i;
    if (step_q == S_EMIT && !emit_busy) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= S_IDLE;
      heap_q      <= OFF_W'(4096);
      out_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        heap_q <= cfg_heap_bytes_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    i_q       <= i_d;
    res_ok_q  <= res_ok_d;
    res_off_q <= res_off_d;
    if (in_accept) begin
      op_q    <= in_opcode_i;
      req_w_q <= REQ_W'((14'(in_request_bytes_i) + 14'd3) >> 2);
      fw_q    <= in_free_offset_i[OFF_W-1:2];
    end
    if (step_q == S_EMIT && !emit_busy) begin
      out_off_q <= res_off_q;
      out_ok_q  <= res_ok_q;
    end
  end

  ffha_ram #(
    .WIDTH(WORD_W),
    .DEPTH(HEAP_WORDS)
  ) u_ram (
    .clk_i  (clk_i),
    .en_i   (ram_en),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  assign out_valid_o          = out_valid_q;
  assign out_payload_offset_o = out_off_q;
  assign out_success_o        = out_ok_q;

  a_rise_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(step_q == S_EMIT))
    else $error("output valid rose outside the emit step");

  a_accept_dispatch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> step_q == S_DISP)
    else $error("accepted beat did not enter dispatch");

  a_walk_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q == S_ALOOP) |-> (32'(i_q) < HEAP_WORDS))
    else $error("header walk index beyond RAM depth");

  a_alloc_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q == S_EMIT && res_ok_q && op_q == OP_ALLOC) |-> (res_off_q != '0))
    else $error("successful allocation with zero offset");

  a_free_ok_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q == S_FREE1) |=> (res_ok_q && res_off_q == '0))
    else $error("free result not marked successful");

endmodule
